// ===== src/csa_pkg.sv =====
// Shared types and constants for the code slot allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package csa_pkg;

	localparam int CODE_W   = 10;
	localparam int SIZE_W   = 8;
	localparam int ELEC_W   = 8;
	localparam int UNIT_W   = 6;
	localparam int STATUS_W = 2;

	// Bitmap words are 16 codes wide; a code splits into word address and bit.
	localparam int WORD_W = 16;
	localparam int BIT_W  = 4;

	// Highest code that may ever be handed out, before the code space limit.
	localparam int TOP_CODE = 999;

	// Intermediate widths of the preferred code arithmetic.
	localparam int QUO_W  = 5;    // ceil(size / 10), at most 26
	localparam int RND_W  = 9;    // size rounded up to a multiple of ten
	localparam int PROD_W = 15;   // unit * rounded size
	localparam int SUM_W  = 15;   // start + product + electrode

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

	// Search window inside one bitmap word.
	typedef struct packed {
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} find_req_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_pos;
	} find_rsp_t;

endpackage

// ===== src/code_slot_allocator_unit.sv =====
// Code slot allocator top level: request sequencer around the bitmap memory
// and the shared free-bit finder. Depends on csa_pkg, csa_bitmap, csa_find.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   request  | in_valid / in_ready   | window_start, window_end, array_len,
//            |                       | electrode, unit_index
//   result   | out_valid / out_ready | assigned_code, status
//
// A request passes the setup states (latch, round-up, preferred code, decide)
// and then examines bitmap words one at a time: the preferred code's word,
// then at most one per 16-code word of the window, before the result is
// offered; the bitmap read port sets that pace.
// After reset a clearing pass sweeps all 2**AW bitmap words (64 by default),
// and in_ready stays low during it. One request is in work at a time;
// in_ready is low from acceptance until its result transfer.
`timescale 1ns / 1ps

module code_slot_allocator_unit #(
	parameter int CODE_SPACE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [csa_pkg::CODE_W-1:0]    window_start,
	input  logic [csa_pkg::CODE_W-1:0]    window_end,
	input  logic [csa_pkg::SIZE_W-1:0]    array_len,
	input  logic [csa_pkg::ELEC_W-1:0]    electrode,
	input  logic [csa_pkg::UNIT_W-1:0]    unit_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [csa_pkg::CODE_W-1:0]    assigned_code,
	output logic [csa_pkg::STATUS_W-1:0]  status
);
	import csa_pkg::*;

	// Only codes up to LIMIT are ever stored, so the bitmap is sized from LIMIT.
	localparam int LIMIT_I = (CODE_SPACE - 1 < TOP_CODE) ? CODE_SPACE - 1 : TOP_CODE;
	localparam int USED    = LIMIT_I + 1;
	localparam int WORDS   = (USED + WORD_W - 1) / WORD_W;
	localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [CODE_W-1:0] LIMIT = CODE_W'(LIMIT_I);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_QUO    = 3'd1;
	localparam logic [2:0] S_PREF   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_EVAL   = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [CODE_W-1:0]   start_q, end_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ELEC_W-1:0]   elec_q;
	logic [UNIT_W-1:0]   unit_q;
	logic [QUO_W-1:0]    quo_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AW-1:0]       cur_q, cur_d;
	logic                scan_q, scan_d;
	logic [CODE_W-1:0]   code_q, code_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic                mem_busy;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [WORD_W-1:0]   rd_data;
	logic                wr_en;
	logic [WORD_W-1:0]   wr_data;
	find_req_t           freq;
	find_rsp_t           frsp;

	logic [16:0]         quo_mul;
	logic [RND_W-1:0]    rounded;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    pref_w;
	logic [CODE_W-1:0]   pref;
	logic                in_win;
	logic [AW-1:0]       end_word, start_word, pref_word;

	// ceil(size / 10) as ((size + 9) * 205) >> 11, exact for these values.
	assign quo_mul = (17'(size_q) + 17'd9) * 17'd205;
	assign rounded = (RND_W'(quo_q) << 3) + (RND_W'(quo_q) << 1);
	assign prod    = PROD_W'(unit_q) * PROD_W'(rounded);

	// The sum holds pref + 1, so an electrode of zero never wraps.
	assign pref_w     = sum_q - SUM_W'(1);
	assign pref       = pref_w[CODE_W-1:0];
	assign in_win     = (sum_q > SUM_W'(start_q)) && (pref_w <= SUM_W'(end_q));
	assign end_word   = end_q[BIT_W +: AW];
	assign start_word = start_q[BIT_W +: AW];
	assign pref_word  = pref[BIT_W +: AW];

	always_comb begin
		if (scan_q) begin
			freq.hi = (cur_q == end_word) ? end_q[BIT_W-1:0] : {BIT_W{1'b1}};
			freq.lo = (cur_q == start_word) ? start_q[BIT_W-1:0] : '0;
		end else begin
			freq.hi = pref[BIT_W-1:0];
			freq.lo = pref[BIT_W-1:0];
		end
	end

	assign wr_data = rd_data | (WORD_W'(1) << frsp.bit_pos);

	always_comb begin
		logic start_scan;
		state_d    = state_q;
		cur_d      = cur_q;
		scan_d     = scan_q;
		code_d     = code_q;
		status_d   = status_q;
		rd_en      = 1'b0;
		rd_addr    = cur_q;
		wr_en      = 1'b0;
		start_scan = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !mem_busy) begin
					state_d = S_QUO;
				end
			end
			S_QUO: begin
				state_d = S_PREF;
			end
			S_PREF: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (in_win && pref > LIMIT) begin
					code_d   = '0;
					status_d = STATUS_BEYOND;
					state_d  = S_OUT;
				end else if (in_win) begin
					rd_en   = 1'b1;
					rd_addr = pref_word;
					cur_d   = pref_word;
					scan_d  = 1'b0;
					state_d = S_EVAL;
				end else begin
					start_scan = 1'b1;
				end
			end
			S_EVAL: begin
				if (frsp.found) begin
					wr_en    = 1'b1;
					code_d   = CODE_W'({cur_q, frsp.bit_pos});
					status_d = STATUS_OK;
					state_d  = S_OUT;
				end else if (!scan_q) begin
					start_scan = 1'b1;
				end else if (cur_q == start_word) begin
					code_d   = '0;
					status_d = STATUS_FULL;
					state_d  = S_OUT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_q - AW'(1);
					cur_d   = cur_q - AW'(1);
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Downward scan from the window end; an empty window reports full, and it stops at once past the limit.
		if (start_scan) begin
			if (start_q > end_q) begin
				code_d   = '0;
				status_d = STATUS_FULL;
				state_d  = S_OUT;
			end else if (end_q > LIMIT) begin
				code_d   = '0;
				status_d = STATUS_BEYOND;
				state_d  = S_OUT;
			end else begin
				rd_en   = 1'b1;
				rd_addr = end_word;
				cur_d   = end_word;
				scan_d  = 1'b1;
				state_d = S_EVAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !mem_busy) begin
			start_q <= window_start;
			end_q   <= window_end;
			size_q  <= array_len;
			elec_q  <= electrode;
			unit_q  <= unit_index;
		end
		if (state_q == S_QUO) begin
			quo_q <= quo_mul[11 +: QUO_W];
		end
		if (state_q == S_PREF) begin
			sum_q <= SUM_W'(start_q) + SUM_W'(prod) + SUM_W'(elec_q);
		end
		cur_q    <= cur_d;
		code_q   <= code_d;
		status_q <= status_d;
	end

	csa_bitmap #(
		.AW(AW)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(cur_q),
		.wr_data(wr_data),
		.busy   (mem_busy)
	);

	csa_find u_find (
		.word(rd_data),
		.req (freq),
		.rsp (frsp)
	);

	assign in_ready      = (state_q == S_IDLE) && !mem_busy;
	assign out_valid     = (state_q == S_OUT);
	assign assigned_code = code_q;
	assign status        = status_q;

endmodule

// ===== src/csa_bitmap.sv =====
// Taken-code bitmap: one word-wide memory with a registered read port,
// one write port and a clearing pass after reset. Depends on csa_pkg.
`timescale 1ns / 1ps

module csa_bitmap #(
	parameter int AW = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [csa_pkg::WORD_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [csa_pkg::WORD_W-1:0] wr_data,
	output logic                      busy
);
	import csa_pkg::*;

	localparam int DEPTH = 2 ** AW;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [AW-1:0]     clr_addr_q;
	logic              clearing_q;

	logic              w_en;
	logic [AW-1:0]     w_addr;
	logic [WORD_W-1:0] w_data;

	// The clearing pass owns the write port until it has swept every word.
	always_comb begin
		if (clearing_q) begin
			w_en   = 1'b1;
			w_addr = clr_addr_q;
			w_data = (clr_addr_q == '0) ? WORD_W'(1) : '0;
		end else begin
			w_en   = wr_en;
			w_addr = wr_addr;
			w_data = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (w_en) begin
			mem[w_addr] <= w_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clearing_q;

endmodule

// ===== src/csa_find.sv =====
// Free-bit finder: highest clear bit of one bitmap word inside [lo, hi].
// Purely combinational; depends on csa_pkg.
`timescale 1ns / 1ps

module csa_find (
	input  logic [csa_pkg::WORD_W-1:0] word,
	input  csa_pkg::find_req_t         req,
	output csa_pkg::find_rsp_t         rsp
);
	import csa_pkg::*;

	logic [WORD_W-1:0] cand;

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			cand[i] = !word[i] && (BIT_W'(i) >= req.lo) && (BIT_W'(i) <= req.hi);
		end
	end

	// Priority from the top, so the highest free code wins.
	always_comb begin
		rsp.found   = 1'b0;
		rsp.bit_pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (cand[i]) begin
				rsp.found   = 1'b1;
				rsp.bit_pos = BIT_W'(i);
			end
		end
	end

endmodule

// ===== src/csa_checker.sv =====
// Port-level checker for the code slot allocator, bound to the top level.
// Depends on csa_pkg and code_slot_allocator_unit.
`timescale 1ns / 1ps

module csa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [csa_pkg::CODE_W-1:0]   assigned_code,
	input logic [csa_pkg::STATUS_W-1:0] status
);
	import csa_pkg::*;

	// A result that waits must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(assigned_code) && $stable(status))
		else $error("result changed while stalled");

	// Failures always report code zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> assigned_code == '0)
		else $error("error result with nonzero code");

	// Code zero is taken at reset, so a good result never returns it.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> assigned_code != '0)
		else $error("code zero handed out");

	// Only one request is in work: acceptance drops ready.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("request accepted while busy");

endmodule

bind code_slot_allocator_unit csa_checker u_csa_checker (.*);

// ===== dv/code_slot_allocator_unit_tb.sv =====
// Self-checking testbench for the code slot allocator: directed and random requests,
// with results checked against a local allocation predictor. Depends on csa_pkg and
// code_slot_allocator_unit.
`timescale 1ns / 1ps

module code_slot_allocator_unit_tb;
	import csa_pkg::*;

	localparam int CODE_SPACE   = 1024;
	localparam int HIGHEST_CODE = (TOP_CODE < CODE_SPACE - 1) ? TOP_CODE : CODE_SPACE - 1;
	localparam int ROUND_STEP   = 10;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 100;
	localparam int LIMIT_NS     = 8_000_000;

	typedef struct {
		logic [CODE_W-1:0] win_lo;
		logic [CODE_W-1:0] win_hi;
		logic [SIZE_W-1:0] arr_size;
		logic [ELEC_W-1:0] elec;
		logic [UNIT_W-1:0] unit;
	} request_t;

	typedef struct {
		logic [CODE_W-1:0]   code;
		logic [STATUS_W-1:0] stat;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CODE_W-1:0]   window_start = '0;
	logic [CODE_W-1:0]   window_end = '0;
	logic [SIZE_W-1:0]   array_len = '0;
	logic [ELEC_W-1:0]   electrode = '0;
	logic [UNIT_W-1:0]   unit_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CODE_W-1:0]   assigned_code;
	logic [STATUS_W-1:0] status;

	// Predictor state: one bit per code, set once the code has been handed out.
	bit     code_taken [CODE_SPACE];
	grant_t expected_grants [$];

	int mismatches = 0;
	int items_sent = 0;
	int grants_seen = 0;
	int burst_left = 0;
	int hold_asks = 0;

	code_slot_allocator_unit #(
		.CODE_SPACE(CODE_SPACE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.window_start(window_start),
		.window_end(window_end),
		.array_len(array_len),
		.electrode(electrode),
		.unit_index(unit_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.assigned_code(assigned_code),
		.status(status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	function automatic request_t make_request(int lo, int hi, int sz, int el, int un);
		request_t r;
		r.win_lo = CODE_W'(lo);
		r.win_hi = CODE_W'(hi);
		r.arr_size = SIZE_W'(sz);
		r.elec = ELEC_W'(el);
		r.unit = UNIT_W'(un);
		return r;
	endfunction

	// Picks the code the block should grant and marks it taken.
	function automatic grant_t allocate_code(request_t r);
		grant_t g;
		int lo, hi, rounded, pref, n;
		lo = int'(r.win_lo);
		hi = int'(r.win_hi);
		rounded = ((int'(r.arr_size) + ROUND_STEP - 1) / ROUND_STEP) * ROUND_STEP;
		pref = lo + int'(r.unit) * rounded + int'(r.elec) - 1;
		g.code = '0;
		g.stat = STATUS_FULL;
		if (pref >= lo && pref <= hi) begin
			if (pref > HIGHEST_CODE) begin
				g.stat = STATUS_BEYOND;
				return g;
			end
			if (!code_taken[pref]) begin
				code_taken[pref] = 1'b1;
				g.code = CODE_W'(pref);
				g.stat = STATUS_OK;
				return g;
			end
		end
		for (n = hi; n >= lo; n--) begin
			if (n > HIGHEST_CODE) begin
				g.stat = STATUS_BEYOND;
				return g;
			end
			if (!code_taken[n]) begin
				code_taken[n] = 1'b1;
				g.code = CODE_W'(n);
				g.stat = STATUS_OK;
				return g;
			end
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH result %0d %s: got %0d expected %0d at %0t ns",
			grants_seen, what, got, want, $time);
		mismatches++;
	endtask

	// Offers one request in the current burst and records its expected grant on transfer.
	task automatic send_request(request_t r);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 12);
				default: gap = $urandom_range(1, 90);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		window_start <= r.win_lo;
		window_end <= r.win_hi;
		array_len <= r.arr_size;
		electrode <= r.elec;
		unit_index <= r.unit;
		do @(posedge clk); while (!in_ready);
		expected_grants.push_back(allocate_code(r));
		items_sent++;
		burst_left--;
	endtask

	// Always waits for a clock edge before it returns, so the next driver never shares this time step.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_grants.size() != 0);
	endtask

	// Requests of one channel in unit-major order, electrodes ascending within a unit.
	task automatic send_channel_sequence();
		request_t r;
		int rounded, units, hi, e, n_el;
		r.arr_size = SIZE_W'($urandom_range(1, 40));
		rounded = ((int'(r.arr_size) + ROUND_STEP - 1) / ROUND_STEP) * ROUND_STEP;
		units = int'($urandom_range(1, 3));
		r.win_lo = CODE_W'($urandom_range(0, 960));
		hi = int'(r.win_lo) + units * rounded - 1 + int'($urandom_range(0, 12)) - 4;
		if (hi < int'(r.win_lo))
			hi = int'(r.win_lo);
		if (hi > CODE_SPACE - 1)
			hi = CODE_SPACE - 1;
		r.win_hi = CODE_W'(hi);
		for (int u = 0; u < units; u++) begin
			r.unit = UNIT_W'(u);
			e = 0;
			n_el = int'($urandom_range(1, 4));
			for (int k = 0; k < n_el; k++) begin
				e += int'($urandom_range(1, 3));
				if (e > int'(r.arr_size))
					break;
				r.elec = ELEC_W'(e);
				send_request(r);
			end
		end
	endtask

	// Result side: stall patterns change at random; a hold request from the test
	// sequence drops out_ready and blocks every transfer while it is served.
	initial begin : result_sink
		int mode, mode_left, hold_served;
		logic [31:0] mask;
		logic [4:0] phase;
		mode = 0;
		mode_left = 0;
		hold_served = 0;
		mask = '1;
		phase = '0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
				mask = $urandom | 32'h1;
			end
			mode_left--;
			phase++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= mask[phase];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin : grant_check
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			grants_seen++;
			if (expected_grants.size() == 0) begin
				report_mismatch("with nothing pending, code", int'(assigned_code), 0);
			end else begin
				want = expected_grants.pop_front();
				if (assigned_code !== want.code)
					report_mismatch("assigned_code", int'(assigned_code), int'(want.code));
				if (status !== want.stat)
					report_mismatch("status", int'(status), int'(want.stat));
			end
		end
	end

	task automatic test_preferred_codes();
		send_request(make_request(100, 199, 8, 1, 0));
		send_request(make_request(100, 199, 8, 8, 0));
		send_request(make_request(100, 199, 8, 1, 1));
		send_request(make_request(100, 199, 8, 3, 2));
		wait_for_results();
	endtask

	// Preferred code already taken, then preferred code past the window end.
	task automatic test_occupied_fallback();
		send_request(make_request(100, 199, 8, 1, 0));
		send_request(make_request(100, 105, 8, 1, 3));
		wait_for_results();
	endtask

	task automatic test_electrode_zero();
		send_request(make_request(200, 220, 10, 0, 0));
		send_request(make_request(0, 5, 10, 0, 0));
		wait_for_results();
	endtask

	task automatic test_zero_array_size();
		send_request(make_request(300, 310, 0, 1, 0));
		send_request(make_request(300, 310, 0, 1, 1));
		send_request(make_request(300, 310, 0, 1, 2));
		wait_for_results();
	endtask

	task automatic test_beyond_code_space();
		send_request(make_request(1000, 1023, 10, 1, 0));
		send_request(make_request(990, 1023, 0, 1, 0));
		send_request(make_request(990, 1023, 0, 1, 0));
		wait_for_results();
	endtask

	task automatic test_empty_and_full_windows();
		send_request(make_request(500, 400, 10, 1, 0));
		repeat (4) send_request(make_request(600, 602, 10, 1, 0));
		send_request(make_request(0, 0, 10, 1, 0));
		wait_for_results();
	endtask

	task automatic test_field_extremes();
		send_request(make_request(1023, 1023, 255, 255, 63));
		send_request(make_request(0, 1023, 255, 255, 63));
		send_request(make_request(0, 999, 255, 255, 0));
		send_request(make_request(0, 0, 0, 0, 0));
		wait_for_results();
	endtask

	// The receiver blocks long enough for the single request slot to fill and
	// the input to stall while further requests wait.
	task automatic test_output_backpressure();
		hold_asks <= hold_asks + 1;
		repeat (6) send_request(make_request($urandom_range(0, 990), 1023,
			$urandom_range(0, 40), $urandom_range(1, 20), $urandom_range(0, 3)));
		wait_for_results();
	endtask

	task automatic test_sender_pause();
		repeat (3) send_channel_sequence();
		wait_for_results();
		repeat (3) send_channel_sequence();
		wait_for_results();
	endtask

	task automatic test_random_requests();
		request_t r;
		int pick, hi, stop_at, next_pause;
		stop_at = items_sent + RANDOM_ITEMS;
		next_pause = items_sent + $urandom_range(60, 200);
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_channel_sequence();
			end else begin
				if (pick < 85) begin
					r.win_lo = CODE_W'($urandom_range(0, 1000));
					hi = int'(r.win_lo) + int'($urandom_range(0, 40));
					r.win_hi = CODE_W'((hi > CODE_SPACE - 1) ? CODE_SPACE - 1 : hi);
					r.arr_size = SIZE_W'($urandom_range(0, 255));
					r.elec = ELEC_W'($urandom_range(0, 20));
					r.unit = UNIT_W'($urandom_range(0, 5));
				end else if (pick < 95) begin
					r.win_lo = CODE_W'($urandom);
					r.win_hi = CODE_W'($urandom);
					r.arr_size = SIZE_W'($urandom);
					r.elec = ELEC_W'($urandom);
					r.unit = UNIT_W'($urandom);
				end else if (pick < 98) begin
					r.win_hi = CODE_W'($urandom_range(0, 1022));
					r.win_lo = CODE_W'($urandom_range(int'(r.win_hi) + 1, 1023));
					r.arr_size = SIZE_W'($urandom);
					r.elec = ELEC_W'($urandom);
					r.unit = UNIT_W'($urandom);
				end else begin
					r.win_lo = CODE_W'($urandom_range(1000, 1023));
					r.win_hi = CODE_W'($urandom_range(int'(r.win_lo), 1023));
					r.arr_size = SIZE_W'($urandom);
					r.elec = ELEC_W'($urandom);
					r.unit = UNIT_W'($urandom);
				end
				send_request(r);
			end
			if (items_sent >= next_pause) begin
				wait_for_results();
				next_pause = items_sent + $urandom_range(60, 200);
			end
		end
		wait_for_results();
	endtask

	initial begin
		for (int i = 0; i < CODE_SPACE; i++)
			code_taken[i] = 1'b0;
		code_taken[0] = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_preferred_codes();
		test_occupied_fallback();
		test_electrode_zero();
		test_zero_array_size();
		test_beyond_code_space();
		test_empty_and_full_windows();
		test_field_extremes();
		test_output_backpressure();
		test_sender_pause();
		test_random_requests();

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_grants.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
